>>> design/gpr_pkg.sv
// Shared types and constants for the gamepad I/O port register block.
package gpr_pkg;

  // Request kinds carried on the input channel's tuser.
  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_BUTTON = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Register kinds produced by the address decoder.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_VERSION,
    KIND_DATA,
    KIND_DIR,
    KIND_TX,
    KIND_RX,
    KIND_SCTRL
  } kind_t;

  // Field widths.
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned BUTTON_W = 3;

  // Register window layout.
  localparam logic [ADDR_W-1:0] VERSION_ADDR = 5'h01;
  localparam logic [ADDR_W-1:0] DATA_BASE    = 5'h03;
  localparam logic [ADDR_W-1:0] DIR_BASE     = 5'h09;
  localparam logic [ADDR_W-1:0] TX_BASE      = 5'h0F;
  localparam logic [ADDR_W-1:0] RX_BASE      = 5'h11;
  localparam logic [ADDR_W-1:0] SCTRL_BASE   = 5'h13;
  localparam logic [ADDR_W-1:0] PORT_STEP    = 5'h02;
  localparam logic [ADDR_W-1:0] SERIAL_STEP  = 5'h06;

  // Read constants and masks.
  localparam logic [DATA_W-1:0] TH_HIGH_MASK  = 8'h3F;
  localparam logic [DATA_W-1:0] TH_LOW_MASK   = 8'h33;
  localparam logic [DATA_W-1:0] UNMAPPED_READ = 8'hFF;
  localparam logic [DATA_W-1:0] RX_READ       = 8'h00;
  localparam logic [DATA_W-1:0] VERSION_RESET = 8'hA0;
  localparam int unsigned       TH_BIT        = 6;

  // Button bit positions in the held mask.
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;
  localparam int unsigned BTN_A     = 4;
  localparam int unsigned BTN_B     = 5;
  localparam int unsigned BTN_C     = 6;
  localparam int unsigned BTN_START = 7;

endpackage

>>> design/gamepad_io_port_registers_top.sv
// Top level of the gamepad I/O port register block.
//
// Requests arrive on the in_ stream: in_tuser carries the request kind
// (bus read, bus write or button event) and in_tdata the address, write
// byte, button number and press flag. Only a bus read returns a result,
// one byte on the out_ stream; writes, button events and the unused kind
// return nothing. The version register is loaded through cfg_we and
// cfg_wdata, by the user only while the block is idle; the block does not enforce it.
//
// Decode, register update and read mux are one combinational pass ahead of
// a single output register, so a read result appears in the cycle after
// its request is accepted. One request is accepted per cycle; the output
// register is the only storage between the two sides, so a request is
// taken whenever that register is empty or being drained in the same cycle.
// If the receiver stalls with a result waiting, in_tready drops until the
// result is taken.
//
// Reset clears all port registers and the held buttons, loads the version
// register with 0xA0 and empties the output register.
module gamepad_io_port_registers_top #(
  parameter int unsigned NUM_PORTS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // addr[4:0], wdata[12:5], button[15:13], pressed[16]
  input  logic [1:0]  in_tuser,   // func[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // rdata[7:0]
  // Configuration port.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int unsigned PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Register state.
  logic [gpr_pkg::DATA_W-1:0] drive_r     [NUM_PORTS];
  logic [gpr_pkg::DATA_W-1:0] direction_r [NUM_PORTS];
  logic [gpr_pkg::DATA_W-1:0] transmit_r  [NUM_PORTS];
  logic [gpr_pkg::DATA_W-1:0] sctrl_r     [NUM_PORTS];
  logic [gpr_pkg::DATA_W-1:0] buttons_r;
  logic [gpr_pkg::DATA_W-1:0] version_r;
  logic                       out_valid_r;
  logic [gpr_pkg::DATA_W-1:0] out_data_r;

  // Unpacked request fields.
  gpr_pkg::func_t               func;
  logic [gpr_pkg::ADDR_W-1:0]   off;
  logic [gpr_pkg::DATA_W-1:0]   wdata;
  logic [gpr_pkg::BUTTON_W-1:0] button;
  logic                         pressed;
  logic                         accept;

  // Decode and read results.
  gpr_pkg::kind_t             kind;
  logic [PIDX_W-1:0]          port;
  logic [gpr_pkg::DATA_W-1:0] held;
  logic [gpr_pkg::DATA_W-1:0] pad_in;
  logic [gpr_pkg::DATA_W-1:0] drv;
  logic [gpr_pkg::DATA_W-1:0] dir;
  logic [gpr_pkg::DATA_W-1:0] rdata;
  logic [gpr_pkg::DATA_W-1:0] buttons_nxt;
  logic [gpr_pkg::DATA_W-1:0] button_bit;

  assign func    = gpr_pkg::func_t'(in_tuser);
  assign off     = in_tdata[4:0] | gpr_pkg::ADDR_W'(1);
  assign wdata   = in_tdata[12:5];
  assign button  = in_tdata[15:13];
  assign pressed = in_tdata[16];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Address decode: first matching port wins, ports beyond NUM_PORTS unmapped.
  always_comb begin
    kind = gpr_pkg::KIND_NONE;
    port = '0;
    if (off == gpr_pkg::VERSION_ADDR) begin
      kind = gpr_pkg::KIND_VERSION;
    end else begin
      for (int n = 0; n < NUM_PORTS; n++) begin
        if (kind == gpr_pkg::KIND_NONE) begin
          if (off == gpr_pkg::DATA_BASE + gpr_pkg::ADDR_W'(n) * gpr_pkg::PORT_STEP) begin
            kind = gpr_pkg::KIND_DATA;
            port = PIDX_W'(n);
          end else if (off == gpr_pkg::DIR_BASE
                       + gpr_pkg::ADDR_W'(n) * gpr_pkg::PORT_STEP) begin
            kind = gpr_pkg::KIND_DIR;
            port = PIDX_W'(n);
          end else if (off == gpr_pkg::TX_BASE
                       + gpr_pkg::ADDR_W'(n) * gpr_pkg::SERIAL_STEP) begin
            kind = gpr_pkg::KIND_TX;
            port = PIDX_W'(n);
          end else if (off == gpr_pkg::RX_BASE
                       + gpr_pkg::ADDR_W'(n) * gpr_pkg::SERIAL_STEP) begin
            kind = gpr_pkg::KIND_RX;
            port = PIDX_W'(n);
          end else if (off == gpr_pkg::SCTRL_BASE
                       + gpr_pkg::ADDR_W'(n) * gpr_pkg::SERIAL_STEP) begin
            kind = gpr_pkg::KIND_SCTRL;
            port = PIDX_W'(n);
          end
        end
      end
    end
  end

  // Pad input bits: only port one has a pad, active low, TH picks the group.
  always_comb begin
    held = (port == '0) ? buttons_r : '0;
    drv  = drive_r[port];
    dir  = direction_r[port];
    if (drv[gpr_pkg::TH_BIT]) begin
      pad_in = gpr_pkg::TH_HIGH_MASK & ~{2'b00,
                                         held[gpr_pkg::BTN_C],
                                         held[gpr_pkg::BTN_B],
                                         held[gpr_pkg::BTN_RIGHT],
                                         held[gpr_pkg::BTN_LEFT],
                                         held[gpr_pkg::BTN_DOWN],
                                         held[gpr_pkg::BTN_UP]};
    end else begin
      pad_in = gpr_pkg::TH_LOW_MASK & ~{2'b00,
                                        held[gpr_pkg::BTN_START],
                                        held[gpr_pkg::BTN_A],
                                        2'b00,
                                        held[gpr_pkg::BTN_DOWN],
                                        held[gpr_pkg::BTN_UP]};
    end
  end

  // Read mux.
  always_comb begin
    case (kind)
      gpr_pkg::KIND_VERSION: rdata = version_r;
      gpr_pkg::KIND_DATA:    rdata = (drv & dir) | (pad_in & ~dir);
      gpr_pkg::KIND_DIR:     rdata = dir;
      gpr_pkg::KIND_TX:      rdata = transmit_r[port];
      gpr_pkg::KIND_SCTRL:   rdata = sctrl_r[port];
      gpr_pkg::KIND_RX:      rdata = gpr_pkg::RX_READ;
      default:               rdata = gpr_pkg::UNMAPPED_READ;
    endcase
  end

  // Held-button update for a button event.
  assign button_bit  = gpr_pkg::DATA_W'(1) << button;
  assign buttons_nxt = pressed ? (buttons_r | button_bit) : (buttons_r & ~button_bit);

  // Register writes, button events and version configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NUM_PORTS; n++) begin
        drive_r[n]     <= '0;
        direction_r[n] <= '0;
        transmit_r[n]  <= '0;
        sctrl_r[n]     <= '0;
      end
      buttons_r <= '0;
      version_r <= gpr_pkg::VERSION_RESET;
    end else begin
      if (cfg_we) begin
        version_r <= cfg_wdata;
      end
      if (accept) begin
        case (func)
          gpr_pkg::FUNC_WRITE: begin
            case (kind)
              gpr_pkg::KIND_DATA:  drive_r[port]     <= wdata;
              gpr_pkg::KIND_DIR:   direction_r[port] <= wdata;
              gpr_pkg::KIND_TX:    transmit_r[port]  <= wdata;
              gpr_pkg::KIND_SCTRL: sctrl_r[port]     <= wdata;
              default: ;
            endcase
          end
          gpr_pkg::FUNC_BUTTON: buttons_r <= buttons_nxt;
          default: ;
        endcase
      end
    end
  end

  // Output register: loaded by an accepted read, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && func == gpr_pkg::FUNC_READ) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && func == gpr_pkg::FUNC_READ) begin
      out_data_r <= rdata;
    end
  end

endmodule

>>> dv/gpr_checker.sv
// Checker for the gamepad I/O port register block: it predicts every read result and compares it.
`timescale 1ns / 100ps

module gpr_checker #(
  parameter int unsigned NUM_PORTS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // addr[4:0], wdata[12:5], button[15:13], pressed[16]
  input  logic [1:0]  in_tuser,   // func[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // rdata[7:0]
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  // Shadow copy of the register file and the held buttons.
  logic [7:0] version_r;
  logic [7:0] drive_r    [NUM_PORTS];
  logic [7:0] dir_r      [NUM_PORTS];
  logic [7:0] ser_tx_r   [NUM_PORTS];
  logic [7:0] ser_ctrl_r [NUM_PORTS];
  logic [7:0] held_r;

  // Read bytes still owed by the block, oldest first.
  logic [7:0] rdata_expected_q [$];

  // Map a folded offset to a register kind and the port that owns it.
  function automatic gpr_pkg::kind_t decode_reg(input logic [4:0] off,
                                                output int unsigned port);
    port = 0;
    if (off == gpr_pkg::VERSION_ADDR) return gpr_pkg::KIND_VERSION;
    for (int unsigned n = 0; n < NUM_PORTS; n++) begin
      port = n;
      if (off == 5'(gpr_pkg::DATA_BASE + n * gpr_pkg::PORT_STEP))
        return gpr_pkg::KIND_DATA;
      if (off == 5'(gpr_pkg::DIR_BASE + n * gpr_pkg::PORT_STEP))
        return gpr_pkg::KIND_DIR;
      if (off == 5'(gpr_pkg::TX_BASE + n * gpr_pkg::SERIAL_STEP))
        return gpr_pkg::KIND_TX;
      if (off == 5'(gpr_pkg::RX_BASE + n * gpr_pkg::SERIAL_STEP))
        return gpr_pkg::KIND_RX;
      if (off == 5'(gpr_pkg::SCTRL_BASE + n * gpr_pkg::SERIAL_STEP))
        return gpr_pkg::KIND_SCTRL;
    end
    port = 0;
    return gpr_pkg::KIND_NONE;
  endfunction

  // Byte seen on a data read: driven bits where the direction is out,
  // active-low pad bits elsewhere. Only port one has a pad attached.
  function automatic logic [7:0] pad_byte(input int unsigned port);
    logic [7:0] held;
    logic [7:0] pins;
    held = (port == 0) ? held_r : 8'h00;
    if (drive_r[port][gpr_pkg::TH_BIT]) begin
      pins = gpr_pkg::TH_HIGH_MASK & ~{2'b00, held[gpr_pkg::BTN_C], held[gpr_pkg::BTN_B],
                                       held[gpr_pkg::BTN_RIGHT], held[gpr_pkg::BTN_LEFT],
                                       held[gpr_pkg::BTN_DOWN], held[gpr_pkg::BTN_UP]};
    end else begin
      pins = gpr_pkg::TH_LOW_MASK & ~{2'b00, held[gpr_pkg::BTN_START], held[gpr_pkg::BTN_A],
                                      2'b00, held[gpr_pkg::BTN_DOWN], held[gpr_pkg::BTN_UP]};
    end
    return (drive_r[port] & dir_r[port]) | (pins & ~dir_r[port]);
  endfunction

  // Apply one accepted request to the shadow state; a read owes one byte.
  task automatic apply_request(input gpr_pkg::func_t f, input logic [4:0] addr,
                               input logic [7:0] wd, input logic [2:0] btn, input logic prs);
    gpr_pkg::kind_t kind;
    int unsigned    port;
    logic [7:0]     rd;
    case (f)
      gpr_pkg::FUNC_BUTTON: begin
        held_r[btn] = prs;
      end
      gpr_pkg::FUNC_WRITE: begin
        kind = decode_reg(addr | 5'h01, port);
        case (kind)
          gpr_pkg::KIND_DATA:  drive_r[port]    = wd;
          gpr_pkg::KIND_DIR:   dir_r[port]      = wd;
          gpr_pkg::KIND_TX:    ser_tx_r[port]   = wd;
          gpr_pkg::KIND_SCTRL: ser_ctrl_r[port] = wd;
          default: ;
        endcase
      end
      gpr_pkg::FUNC_READ: begin
        kind = decode_reg(addr | 5'h01, port);
        case (kind)
          gpr_pkg::KIND_VERSION: rd = version_r;
          gpr_pkg::KIND_DATA:    rd = pad_byte(port);
          gpr_pkg::KIND_DIR:     rd = dir_r[port];
          gpr_pkg::KIND_TX:      rd = ser_tx_r[port];
          gpr_pkg::KIND_SCTRL:   rd = ser_ctrl_r[port];
          gpr_pkg::KIND_RX:      rd = gpr_pkg::RX_READ;
          default:               rd = gpr_pkg::UNMAPPED_READ;
        endcase
        rdata_expected_q.push_back(rd);
      end
      default: ;
    endcase
  endtask

  // Track reset, version writes, results and requests at each clock edge.
  always @(posedge clk) begin : monitor
    logic [7:0] want;
    if (!rst_n) begin
      version_r = gpr_pkg::VERSION_RESET;
      held_r    = 8'h00;
      for (int unsigned i = 0; i < NUM_PORTS; i++) begin
        drive_r[i]    = 8'h00;
        dir_r[i]      = 8'h00;
        ser_tx_r[i]   = 8'h00;
        ser_ctrl_r[i] = 8'h00;
      end
      rdata_expected_q.delete();
    end else begin
      if (cfg_we) version_r = cfg_wdata;
      // A result belongs to a request taken at an earlier edge.
      if (out_tvalid && out_tready) begin
        if (rdata_expected_q.size() == 0) begin
          $error("rdata: unexpected result, expected none, actual 0x%02h", out_tdata);
          fail_count = fail_count + 1;
        end else begin
          want = rdata_expected_q.pop_front();
          if (out_tdata !== want) begin
            $error("rdata mismatch: expected 0x%02h, actual 0x%02h", want, out_tdata);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_request(gpr_pkg::func_t'(in_tuser), in_tdata[4:0], in_tdata[12:5],
                      in_tdata[15:13], in_tdata[16]);
      end
    end
    outstanding <= rdata_expected_q.size();
  end

  // Reads still owed when the run ends.
  final begin
    if (rdata_expected_q.size() != 0)
      $error("rdata: %0d results expected, actual none", rdata_expected_q.size());
  end

endmodule

>>> dv/tb.sv
// Testbench top for the gamepad I/O port register block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned PORTS       = 3;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // addr[4:0], wdata[12:5], button[15:13], pressed[16]
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // rdata[7:0]
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        quiet;
  int          fail_count;
  int          outstanding;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  version_values [4];

  gamepad_io_port_registers_top #(
    .NUM_PORTS(PORTS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  gpr_checker #(
    .NUM_PORTS(PORTS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls in random bursts, none in the quiet stretch.
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Give up when no request or result moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one request, after a random gap unless in the quiet stretch.
  task automatic send_request(input gpr_pkg::func_t f, input logic [4:0] addr,
                              input logic [7:0] wd, input logic [2:0] btn, input logic prs);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {7'd0, prs, btn, wd, addr};
    do @(posedge clk); while (!in_tready);
  endtask

  // Random request; half of the addresses hit the pad's data and direction.
  task automatic random_request();
    int unsigned    pick;
    gpr_pkg::func_t f;
    logic [4:0]     addr;
    pick = $urandom_range(0, 99);
    if (pick < 40) f = gpr_pkg::FUNC_READ;
    else if (pick < 70) f = gpr_pkg::FUNC_WRITE;
    else if (pick < 95) f = gpr_pkg::FUNC_BUTTON;
    else f = gpr_pkg::FUNC_NONE;
    if ($urandom_range(0, 1) == 0) begin
      addr = ($urandom_range(0, 1) == 0) ? gpr_pkg::DATA_BASE : gpr_pkg::DIR_BASE;
      addr[0] = 1'($urandom_range(0, 1));
    end else begin
      addr = 5'($urandom_range(0, 31));
    end
    send_request(f, addr, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)));
  endtask

  // Stop offering and wait until every read has been answered.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  // Load the version register while the block is idle.
  task automatic write_version(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = gpr_pkg::FUNC_READ;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    quiet      = 1'b0;
    version_values[0] = 8'hFF;
    version_values[1] = 8'h00;
    version_values[2] = 8'($urandom_range(1, 254));
    version_values[3] = 8'($urandom_range(1, 254));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: reset values, both button groups, every button,
    // driven bits, the idle port, receive data and the read-only version.
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::VERSION_ADDR, 8'h00, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::DATA_BASE, 8'h00, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_WRITE, gpr_pkg::DATA_BASE, 8'h40, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::DATA_BASE, 8'h00, 3'd0, 1'b0);
    for (int b = 0; b < 8; b++) send_request(gpr_pkg::FUNC_BUTTON, 5'd0, 8'h00, 3'(b), 1'b1);
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::DATA_BASE, 8'h00, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_BUTTON, 5'd0, 8'h00, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_WRITE, gpr_pkg::DIR_BASE, 8'hFF, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_WRITE, gpr_pkg::DATA_BASE, 8'hFF, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::DATA_BASE, 8'h00, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::DATA_BASE + gpr_pkg::PORT_STEP, 8'h00, 3'd0,
                 1'b0);
    send_request(gpr_pkg::FUNC_WRITE,
                 gpr_pkg::TX_BASE + gpr_pkg::SERIAL_STEP + gpr_pkg::SERIAL_STEP, 8'hFF, 3'd7,
                 1'b1);
    send_request(gpr_pkg::FUNC_READ,
                 gpr_pkg::TX_BASE + gpr_pkg::SERIAL_STEP + gpr_pkg::SERIAL_STEP, 8'h00, 3'd0,
                 1'b0);
    send_request(gpr_pkg::FUNC_WRITE, gpr_pkg::RX_BASE, 8'h5A, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::RX_BASE & 5'h1E, 8'h00, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_WRITE, gpr_pkg::VERSION_ADDR, 8'h55, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::VERSION_ADDR, 8'h00, 3'd0, 1'b0);
    send_request(gpr_pkg::FUNC_WRITE, gpr_pkg::SCTRL_BASE + gpr_pkg::SERIAL_STEP, 8'hA5, 3'd0,
                 1'b0);
    send_request(gpr_pkg::FUNC_READ, gpr_pkg::SCTRL_BASE + gpr_pkg::SERIAL_STEP, 8'h00, 3'd0,
                 1'b0);
    send_request(gpr_pkg::FUNC_NONE, gpr_pkg::DATA_BASE, 8'hFF, 3'd7, 1'b1);
    drain();

    // Random phases, each under its own version value; the last one runs
    // without idling on either side.
    for (int phase = 0; phase < 4; phase++) begin
      quiet <= (phase == 3);
      write_version(version_values[phase]);
      repeat (PHASE_ITEMS) random_request();
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
